// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define RMSD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define RMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/rmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsd_pkg
// Widths, operand select codes and controller/datapath bundles for the
// running mean and standard deviation core.
// ----------------------------------------------------------------------------
package rmsd_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int COUNT_WIDTH  = 32;

    // fixed field widths
    localparam int IN_W      = 32;
    localparam int MEAN_W    = 32;
    localparam int SD_W      = 31;
    localparam int CNT_OUT_W = 32;

    // datapath widths
    localparam int MSQ_W  = 64;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = PROD_W;

    // shared divider: two quotient bits per step
    localparam int DIV_W          = 98;
    localparam int QUOT_W         = 64;
    localparam int DIV_STEPS_MEAN = 32;
    localparam int DIV_STEPS_MSQ  = DIV_W / 2;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS_MSQ);

    // square root: one root bit per step
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);

    // multiplier operand selection
    localparam int MUL_SEL_W = 3;
    localparam logic [MUL_SEL_W-1:0] MUL_MEAN_N  = 3'd0;
    localparam logic [MUL_SEL_W-1:0] MUL_X_SQ    = 3'd1;
    localparam logic [MUL_SEL_W-1:0] MUL_MSQ_LO  = 3'd2;
    localparam logic [MUL_SEL_W-1:0] MUL_MSQ_HI  = 3'd3;
    localparam logic [MUL_SEL_W-1:0] MUL_MEAN_SQ = 3'd4;

    typedef struct packed {
        logic                 load;
        logic                 mul_en;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 num_en;
        logic                 sq_en;
        logic                 acc_lo;
        logic                 acc_hi;
        logic                 acc_half;
        logic                 div_start;
        logic                 div_sel_msq;
        logic                 mean_wr;
        logic                 msq_wr;
        logic                 sqrt_start;
        logic                 out_load;
    } rmsd_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
    } rmsd_stat_t;

endpackage

// ===== design/running_mean_stddev_core.sv =====
// A clear request returns an all-zero result.
// Throughput: one request at a time; each sample runs through the
// shared 2-bit-per-cycle divider (32 steps for the mean, 49 for the mean of
// squares) and the 1-bit-per-cycle square root (32 steps) before the next
// request is taken.
// Reset: synchronous, active low; clears count, mean and mean of squares.
// ----------------------------------------------------------------------------
// running_mean_stddev_core
// Running mean, standard deviation and sample count of Q15.16 samples.
// ----------------------------------------------------------------------------
module running_mean_stddev_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic signed [rmsd_pkg::IN_W-1:0]     s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rmsd_pkg::MEAN_W-1:0]   m_mean,
    output logic [rmsd_pkg::SD_W-1:0]            m_std_dev,
    output logic [rmsd_pkg::CNT_OUT_W-1:0]       m_sample_count
);
    import rmsd_pkg::*;

    rmsd_cmd_t  cmd;
    rmsd_stat_t stat;

    rmsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    rmsd_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_cmd          (s_cmd),
        .s_sample       (s_sample),
        .m_mean         (m_mean),
        .m_std_dev      (m_std_dev),
        .m_sample_count (m_sample_count)
    );

endmodule

// ===== design/rmsd_div.sv =====
// ----------------------------------------------------------------------------
// rmsd_div
// Restoring divider, two quotient bits per cycle, dividend taken from the
// top down over a programmable number of steps.
// ----------------------------------------------------------------------------
module rmsd_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [rmsd_pkg::DIV_W-1:0]          dividend,
    input  logic [rmsd_pkg::DIV_CNT_W-1:0]      last_step,
    input  logic [rmsd_pkg::COUNT_WIDTH-1:0]    divisor,
    output logic                                busy,
    output logic [rmsd_pkg::QUOT_W-1:0]         quotient
);
    import rmsd_pkg::*;

    logic                   busy_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]       dvd_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] dvs_reg;
    logic [QUOT_W-1:0]      quot_reg;

    logic [COUNT_WIDTH:0]   t1, t2, d1, d2;
    logic                   ge1, ge2;
    logic [COUNT_WIDTH-1:0] r1, r2;

    always_comb begin
        t1  = {rem_reg, dvd_reg[DIV_W-1]};
        d1  = t1 - {1'b0, dvs_reg};
        ge1 = (t1 >= {1'b0, dvs_reg});
        r1  = ge1 ? d1[COUNT_WIDTH-1:0] : t1[COUNT_WIDTH-1:0];
        t2  = {r1, dvd_reg[DIV_W-2]};
        d2  = t2 - {1'b0, dvs_reg};
        ge2 = (t2 >= {1'b0, dvs_reg});
        r2  = ge2 ? d2[COUNT_WIDTH-1:0] : t2[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= last_step;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[DIV_W-3:0], 2'b00};
            rem_reg  <= r2;
            quot_reg <= {quot_reg[QUOT_W-3:0], ge1, ge2};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// ===== design/rmsd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmsd_sqrt
// Digit-by-digit integer square root, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module rmsd_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rmsd_pkg::RAD_W-1:0]   radicand,
    output logic                         busy,
    output logic [rmsd_pkg::ROOT_W-1:0]  root
);
    import rmsd_pkg::*;

    logic                  busy_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [SREM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [SREM_W+1:0]     rem_sh, trial, diff;
    logic                  ge;

    always_comb begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= SQRT_CNT_W'(ROOT_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[SREM_W-1:0] : rem_sh[SREM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== design/rmsd_datapath.sv =====
// ----------------------------------------------------------------------------
// rmsd_datapath
// Statistics registers, shared multiplier, accumulators, divider, square
// root and output registers, stepped by the controller's commands.
// ----------------------------------------------------------------------------
module rmsd_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rmsd_pkg::rmsd_cmd_t                  cmd,
    output rmsd_pkg::rmsd_stat_t                 stat,
    input  logic                                 s_cmd,
    input  logic signed [rmsd_pkg::IN_W-1:0]     s_sample,
    output logic signed [rmsd_pkg::MEAN_W-1:0]   m_mean,
    output logic [rmsd_pkg::SD_W-1:0]            m_std_dev,
    output logic [rmsd_pkg::CNT_OUT_W-1:0]       m_sample_count
);
    import rmsd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // statistics
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [MSQ_W-1:0]          msq_reg;

    // working registers
    logic signed [MEAN_W-1:0]  x_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [MSQ_W-1:0]          sq_reg;
    logic [DIV_W-1:0]          acc_reg;
    logic                      neg_reg;

    logic signed [MEAN_W-1:0]  mean_out_reg;
    logic [SD_W-1:0]           sd_out_reg;
    logic [CNT_OUT_W-1:0]      cnt_out_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_trunc;
    logic [COUNT_WIDTH-1:0]    count_inc, nm1, half;
    logic signed [MUL_W-1:0]   mul_a, mul_b, nm1_ext, mean_ext;
    logic [MSQ_W-1:0]          half64, mean_dvd;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIV_CNT_W-1:0]      div_last;
    logic                      div_busy, sqrt_busy;
    logic [QUOT_W-1:0]         div_quot;
    logic [MEAN_W-1:0]         q_lo, mean_new;
    logic [MSQ_W:0]            var_diff;
    logic [RAD_W-1:0]          radicand;
    logic [ROOT_W-1:0]         root;
    logic [SD_W-1:0]           sd_sat;

    assign x_trunc   = s_sample[SAMPLE_WIDTH-1:0];
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign nm1       = count_reg - 1'b1;
    assign half      = count_reg >> 1;
    assign half64    = MSQ_W'(half);
    assign nm1_ext   = MUL_W'(nm1);
    assign mean_ext  = MUL_W'(mean_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_MEAN_N: begin
                mul_a = mean_ext;
                mul_b = nm1_ext;
            end
            MUL_X_SQ: begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
            end
            MUL_MSQ_LO: begin
                mul_a = {1'b0, msq_reg[MSQ_W/2-1:0]};
                mul_b = nm1_ext;
            end
            MUL_MSQ_HI: begin
                mul_a = {1'b0, msq_reg[MSQ_W-1:MSQ_W/2]};
                mul_b = nm1_ext;
            end
            MUL_MEAN_SQ: begin
                mul_a = mean_ext;
                mul_b = mean_ext;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // half - num equals |num| + half when num is negative
    assign mean_dvd = num_reg[NUM_W-1] ? (half64 - num_reg[MSQ_W-1:0])
                                       : (num_reg[MSQ_W-1:0] + half64);

    assign div_dividend = cmd.div_sel_msq ? acc_reg
                                          : {mean_dvd, {(DIV_W - MSQ_W){1'b0}}};
    assign div_last     = cmd.div_sel_msq ? DIV_CNT_W'(DIV_STEPS_MSQ - 1)
                                          : DIV_CNT_W'(DIV_STEPS_MEAN - 1);

    assign q_lo     = div_quot[MEAN_W-1:0];
    assign mean_new = neg_reg ? (~q_lo + 1'b1) : q_lo;

    // clamp negative variance to zero
    assign var_diff = {1'b0, msq_reg} - {1'b0, prod_reg[MSQ_W-1:0]};
    assign radicand = var_diff[MSQ_W] ? '0 : var_diff[MSQ_W-1:0];
    assign sd_sat   = root[ROOT_W-1] ? {SD_W{1'b1}} : root[SD_W-1:0];

    rmsd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .last_step (div_last),
        .divisor   (count_reg),
        .busy      (div_busy),
        .quotient  (div_quot)
    );

    rmsd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            mean_reg  <= '0;
            msq_reg   <= '0;
        end else if (cmd.load) begin
            if (s_cmd) begin
                count_reg <= '0;
                mean_reg  <= '0;
                msq_reg   <= '0;
            end else begin
                count_reg <= count_inc;
            end
        end else begin
            if (cmd.mean_wr) begin
                mean_reg <= mean_new;
            end
            if (cmd.msq_wr) begin
                msq_reg <= div_quot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= MEAN_W'(x_trunc);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.num_en) begin
            num_reg <= prod_reg + NUM_W'(x_reg);
        end
        if (cmd.sq_en) begin
            sq_reg <= prod_reg[MSQ_W-1:0];
        end
        if (cmd.div_start && !cmd.div_sel_msq) begin
            neg_reg <= num_reg[NUM_W-1];
        end
        if (cmd.acc_lo) begin
            acc_reg <= DIV_W'(prod_reg[MSQ_W-1:0]) + DIV_W'(sq_reg);
        end else if (cmd.acc_hi) begin
            acc_reg <= acc_reg + DIV_W'({prod_reg[MSQ_W-1:0], {(MSQ_W/2){1'b0}}});
        end else if (cmd.acc_half) begin
            acc_reg <= acc_reg + DIV_W'(half);
        end
        if (cmd.out_load) begin
            mean_out_reg <= mean_reg;
            sd_out_reg   <= sd_sat;
            cnt_out_reg  <= CNT_OUT_W'(count_reg);
        end
    end

    assign stat.div_busy  = div_busy;
    assign stat.sqrt_busy = sqrt_busy;

    assign m_mean         = mean_out_reg;
    assign m_std_dev      = sd_out_reg;
    assign m_sample_count = cnt_out_reg;

endmodule

// ===== design/rmsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmsd_ctrl
// Sequencer: accepts a request, steps the datapath through the mean and
// mean-of-squares updates (skipped on clear) and the root, hands off results.
// ----------------------------------------------------------------------------
module rmsd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_cmd,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rmsd_pkg::rmsd_cmd_t   cmd,
    input  rmsd_pkg::rmsd_stat_t  stat
);
    import rmsd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULM  = 4'd1;
    localparam logic [3:0] S_NUM   = 4'd2;
    localparam logic [3:0] S_DIVM  = 4'd3;
    localparam logic [3:0] S_MULH  = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_HALF  = 4'd6;
    localparam logic [3:0] S_WAITM = 4'd7;
    localparam logic [3:0] S_DIVQ  = 4'd8;
    localparam logic [3:0] S_WAITQ = 4'd9;
    localparam logic [3:0] S_SQM   = 4'd10;
    localparam logic [3:0] S_VAR   = 4'd11;
    localparam logic [3:0] S_WAITS = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    // clear skips straight to the readout
                    state_next = s_cmd ? S_SQM : S_MULM;
                end
            end
            S_MULM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MEAN_N;
                state_next  = S_NUM;
            end
            S_NUM: begin
                cmd.num_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X_SQ;
                state_next  = S_DIVM;
            end
            S_DIVM: begin
                cmd.div_start = 1'b1;
                cmd.sq_en     = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_MSQ_LO;
                state_next    = S_MULH;
            end
            S_MULH: begin
                cmd.acc_lo  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MSQ_HI;
                state_next  = S_ACC;
            end
            S_ACC: begin
                cmd.acc_hi = 1'b1;
                state_next = S_HALF;
            end
            S_HALF: begin
                cmd.acc_half = 1'b1;
                state_next   = S_WAITM;
            end
            S_WAITM: begin
                if (!stat.div_busy) begin
                    cmd.mean_wr = 1'b1;
                    state_next  = S_DIVQ;
                end
            end
            S_DIVQ: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_msq = 1'b1;
                state_next      = S_WAITQ;
            end
            S_WAITQ: begin
                if (!stat.div_busy) begin
                    cmd.msq_wr = 1'b1;
                    state_next = S_SQM;
                end
            end
            S_SQM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MEAN_SQ;
                state_next  = S_VAR;
            end
            S_VAR: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_WAITS;
            end
            S_WAITS: begin
                if (!stat.sqrt_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the previous result has been taken
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== design/rmsd_checker.sv =====
// ----------------------------------------------------------------------------
// rmsd_checker
// Port-level checks on the running mean and standard deviation core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_mean,
    input logic [30:0] m_std_dev,
    input logic [31:0] m_sample_count
);

    `RMSD_ASSERT_ALWAYS(a_reset_drops_valid, aclk, !aresetn |=> !m_valid, "m_valid high after reset")

    `RMSD_ASSERT_CLK(a_one_request_at_a_time, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second request taken while busy")

    `RMSD_ASSERT_CLK(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_mean) && $stable(m_sample_count), "stalled result changed")

    `RMSD_ASSERT_CLK(a_empty_is_zero, aclk, aresetn, m_valid && (m_sample_count == 32'd0) |-> (m_mean == 32'd0) && (m_std_dev == 31'd0), "nonzero statistics with no samples")

    `RMSD_ASSERT_CLK(a_single_no_spread, aclk, aresetn, m_valid && (m_sample_count == 32'd1) |-> (m_std_dev == 31'd0), "nonzero spread after one sample")

endmodule

bind running_mean_stddev_core rmsd_checker u_rmsd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_mean         (m_mean),
    .m_std_dev      (m_std_dev),
    .m_sample_count (m_sample_count)
);

// ===== verif/tb_running_mean_stddev_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_mean_stddev_core
// Self-checking bench for the running mean / standard deviation core. A
// short table of directed requests (extremes, rounding ties, clamped
// variance, clears) is followed by random sample streams with occasional
// clears. Each result is checked against the table or a bit-exact statistics
// model, with random stalls on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_running_mean_stddev_core;

    import rmsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int HOLD_AFTER     = 300;
    localparam int RANDOM_REQS    = 1200;
    localparam int DRAIN_CYCLES   = 300;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [MEAN_W-1:0]    mean;
        logic [SD_W-1:0]             std_dev;
        logic [CNT_OUT_W-1:0]        count;
    } stats_t;

    typedef struct packed {
        logic              cmd;
        logic [IN_W-1:0]   sample;
        logic              typed;
        stats_t            result;
    } dir_row_t;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_valid  = 1'b0;
    logic                          s_ready;
    logic                          s_cmd    = 1'b0;
    logic signed [IN_W-1:0]        s_sample = '0;
    logic                          m_valid;
    logic                          m_ready  = 1'b0;
    logic signed [MEAN_W-1:0]      m_mean;
    logic [SD_W-1:0]               m_std_dev;
    logic [CNT_OUT_W-1:0]          m_sample_count;

    // model state of the statistics
    logic [COUNT_WIDTH-1:0]        cnt_q  = '0;
    logic signed [MEAN_W-1:0]      mean_q = '0;
    logic [MSQ_W-1:0]              msq_q  = '0;

    stats_t   pending_stats[$];
    dir_row_t dir_rows[$];

    int errors       = 0;
    int results_seen = 0;
    int n_adds       = 0;
    int n_clears     = 0;
    int idle_cycles  = 0;
    bit held_off     = 1'b0;

    running_mean_stddev_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mean         (m_mean),
        .m_std_dev      (m_std_dev),
        .m_sample_count (m_sample_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 30);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        int b;
        r = '0;
        for (b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if ({32'b0, t} * {32'b0, t} <= v) r = t;
        end
        return r;
    endfunction

    // Advance the statistics by one request and return the result it produces.
    task automatic stats_advance(input logic cmd, input logic [IN_W-1:0] smp,
                                 output stats_t res);
        logic [63:0]        n;
        logic [63:0]        nm1;
        logic [63:0]        xmag;
        logic [63:0]        sq;
        logic [63:0]        amag;
        logic [63:0]        msq2;
        logic [63:0]        root;
        logic signed [65:0] m66;
        logic signed [65:0] w66;
        logic signed [65:0] x66;
        logic signed [65:0] num;
        logic [65:0]        mag;
        logic [65:0]        q;
        logic [129:0]       wide;
        logic               neg;
        if (cmd == CMD_CLEAR) begin
            cnt_q  = '0;
            mean_q = '0;
            msq_q  = '0;
        end else begin
            if (cnt_q != '1) cnt_q = cnt_q + 1'b1;
            n   = {32'b0, cnt_q};
            nm1 = n - 64'd1;
            m66 = mean_q;
            x66 = $signed(smp);
            w66 = $signed({2'b00, nm1});
            num = m66 * w66 + x66;
            neg = num[65];
            mag = num;
            if (neg) mag = -mag;
            // round to nearest, ties away from zero
            q = (mag + {2'b00, n >> 1}) / {2'b00, n};
            mean_q = neg ? -q[31:0] : q[31:0];

            xmag = x66[63:0];
            if (x66[65]) xmag = -xmag;
            sq = xmag * xmag;
            // round to nearest, ties upward
            wide = {66'b0, msq_q} * {66'b0, nm1} + {66'b0, sq} + {66'b0, n >> 1};
            wide = wide / {66'b0, n};
            msq_q = wide[63:0];
        end
        amag = {{32{mean_q[31]}}, mean_q};
        if (mean_q[31]) amag = -amag;
        msq2 = amag * amag;
        // clamp a variance pushed below zero by rounding
        root = (msq_q > msq2) ? {32'b0, floor_root(msq_q - msq2)} : 64'd0;
        if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
        res.mean    = mean_q;
        res.std_dev = root[SD_W-1:0];
        res.count   = cnt_q;
    endtask

    function automatic dir_row_t mk_row(input logic cmd, input logic [IN_W-1:0] smp,
                                        input logic typed, input logic [31:0] mean,
                                        input logic [31:0] sd, input logic [31:0] cnt);
        dir_row_t row;
        row.cmd            = cmd;
        row.sample         = smp;
        row.typed          = typed;
        row.result.mean    = mean;
        row.result.std_dev = sd[SD_W-1:0];
        row.result.count   = cnt;
        return row;
    endfunction

    function automatic logic [IN_W-1:0] rand_sample();
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2: begin
                return $urandom;
            end
            3, 4, 5: begin
                return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            end
            6: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: begin
                // cluster around a fixed level with small spread
                return 32'h0050_0000 + $urandom_range(0, 32'hFFFF) - 32'h8000;
            end
        endcase
    endfunction

    // Offer one request, hold it until accepted, then queue its expected result.
    task automatic send_req(input logic cmd, input logic [IN_W-1:0] smp,
                            input logic typed, input stats_t typed_res);
        int     gap;
        stats_t pred;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        stats_advance(cmd, smp, pred);
        pending_stats.push_back(typed ? typed_res : pred);
        if (cmd == CMD_CLEAR) n_clears++;
        else n_adds++;
    endtask

    // result checker
    always @(posedge aclk) begin
        stats_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_stats.size() == 0) begin
                $display("%0t: result with nothing pending: mean %h std_dev %h count %0d",
                         $time, m_mean, m_std_dev, m_sample_count);
                errors++;
            end else begin
                e = pending_stats.pop_front();
                if (m_mean !== e.mean) begin
                    $display("%0t: mean expected %h actual %h", $time, e.mean, m_mean);
                    errors++;
                end
                if (m_std_dev !== e.std_dev) begin
                    $display("%0t: std_dev expected %h actual %h",
                             $time, e.std_dev, m_std_dev);
                    errors++;
                end
                if (m_sample_count !== e.count) begin
                    $display("%0t: sample_count expected %0d actual %0d",
                             $time, e.count, m_sample_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no request moved for %0d cycles, %0d results pending",
                         $time, WATCHDOG_LIMIT, pending_stats.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // output side: random stalls, plus one long hold-off to back up the input
    initial begin
        int gap;
        int burst;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = idle_len();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            burst = $urandom_range(1, 40);
            repeat (burst) @(posedge aclk);
        end
    end

    initial begin
        int i;
        dir_row_t row;
        stats_t   none;
        none = '0;

        dir_rows.push_back(mk_row(CMD_ADD,   32'h0000_0003, 1'b1, 32'h0000_0003, 0, 1));
        dir_rows.push_back(mk_row(CMD_CLEAR, 32'h5A5A_5A5A, 1'b1, 32'h0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 0, 1));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h8000_0000, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h8000_0000, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 32'h0000_0000, 1'b1, 32'h0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h8000_0000, 1'b1, 32'h8000_0000, 0, 1));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h7FFF_FFFF, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h0000_0000, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'h0, 0, 0));
        // ties in the mean: +0.5 and -0.5 ulp
        dir_rows.push_back(mk_row(CMD_ADD,   32'h0000_0000, 1'b1, 32'h0, 0, 1));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h0000_0001, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'hFFFF_FFFF, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'hFFFF_FFFE, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 32'h0000_0000, 1'b1, 32'h0, 0, 0));
        // rounded mean squared exceeds rounded mean of squares
        dir_rows.push_back(mk_row(CMD_ADD,   32'h0000_0002, 1'b1, 32'h0000_0002, 0, 1));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h0000_0001, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 32'h0000_0000, 1'b1, 32'h0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h0001_0000, 1'b1, 32'h0001_0000, 0, 1));
        dir_rows.push_back(mk_row(CMD_ADD,   32'hFFFF_0000, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h7FFF_FFFF, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ADD,   32'h8000_0000, 1'b0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'h0, 0, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_req(row.cmd, row.sample, row.typed, row.result);
        end

        for (i = 0; i < RANDOM_REQS; i++) begin
            // mostly sample streams, with a clear now and then
            send_req(($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_ADD, rand_sample(),
                     1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests (%0d samples, %0d clears), %0d results checked, %0d errors",
                 n_adds + n_clears, n_adds, n_clears, results_seen, errors);
        $display("covered: extreme samples, rounding ties, clamped variance, clears, %0s",
                 held_off ? "long output stall" : "no long output stall");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== running_mean_stddev_core.f =====
+incdir+design
design/rmsd_pkg.sv
design/rmsd_div.sv
design/rmsd_sqrt.sv
design/rmsd_datapath.sv
design/rmsd_ctrl.sv
design/running_mean_stddev_core.sv
design/rmsd_checker.sv
verif/tb_running_mean_stddev_core.sv
